[rtl/ptwu_pkg.sv]
package ptwu_pkg;

   // Store geometry
   localparam int LAYERS           = 8;
   localparam int PARAMS_PER_LAYER = 1024;
   localparam int STORE_DEPTH      = LAYERS * PARAMS_PER_LAYER;
   localparam int ADDR_W           = $clog2(STORE_DEPTH);
   localparam int MEM_W            = 64;

   // Pipeline stages between the memory read and the response register
   localparam int NUM_STAGES = 6;

   // Control and status registers
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACE_DECAY  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLORE_PROB = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SCALE  = 2'd3;

   localparam logic [15:0] LEARN_RATE_RST   = 16'd655;
   localparam logic [16:0] TRACE_DECAY_RST  = 17'd58982;
   localparam logic [16:0] EXPLORE_PROB_RST = 17'd6554;
   localparam logic [15:0] NOISE_SCALE_RST  = 16'd256;

   // Commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic        [2:0]  layer;
      logic        [9:0]  position;
      logic signed [31:0] reward;
      logic        [15:0] uniform_draw;
      logic signed [15:0] gauss_draw;
      logic signed [31:0] init_weight;
   } req_type;

   typedef struct packed {
      logic signed [31:0] param_value;
      logic               explored;
   } rsp_type;

   // Per-item control that rides along the pipeline
   typedef struct packed {
      logic               upd;
      logic               ok;
      logic               explored;
      logic [ADDR_W-1:0]  addr;
      logic signed [31:0] init_weight;
   } stage_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/perturbation_trace_weight_update_core.sv]
// Channel   Direction  Handshake              Beat
// req       in         req_valid/req_ready    ptwu_pkg::req_type (load or update command)
// rsp       out        rsp_valid/rsp_ready    ptwu_pkg::rsp_type (param_value, explored)
// csr       in         csr_wr_en (no wait)    csr_index selects register, csr_wdata value
//
// One beat is accepted per cycle while rsp keeps up and no update is held back; its response
// passes the memory read into stage 1, then five arithmetic stages, then the output register.
// An update to an entry whose earlier beat has not yet written back waits for it, and rsp
// stalls lengthen that wait (memory RMW loop).
// Reset (synchronous) clears valid bits and restores register defaults; the memory
// is not cleared. Stages advance independently, so bubbles close up under stalls.

module perturbation_trace_weight_update_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ptwu_pkg::req_type                  req_beat,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ptwu_pkg::rsp_type                  rsp_beat,
   input  logic                               csr_wr_en,
   input  logic [ptwu_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptwu_pkg::CSR_W-1:0]         csr_wdata
);

   import ptwu_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [15:0] learn_rate_ff;
   logic [16:0] trace_decay_ff;
   logic [16:0] explore_prob_ff;
   logic [15:0] noise_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff   <= LEARN_RATE_RST;
         trace_decay_ff  <= TRACE_DECAY_RST;
         explore_prob_ff <= EXPLORE_PROB_RST;
         noise_scale_ff  <= NOISE_SCALE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LEARN_RATE:   learn_rate_ff   <= csr_wdata[15:0];
            CSR_TRACE_DECAY:  trace_decay_ff  <= csr_wdata[16:0];
            CSR_EXPLORE_PROB: explore_prob_ff <= csr_wdata[16:0];
            CSR_NOISE_SCALE:  noise_scale_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: valid bits, per-stage advance, read-after-write interlock
   // ---------------------------------------------------------------------
   logic          valid_ff [1:NUM_STAGES];
   logic          valid_in [1:NUM_STAGES];
   stage_ctl_type ctl_ff   [1:NUM_STAGES];
   logic          mv       [1:NUM_STAGES];
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          o_free;

   stage_ctl_type ctl_in;
   logic          req_ok;
   logic          hit;
   logic          block;
   logic          accept;

   // Stage k may load when it is empty or its occupant moves on
   always_comb begin
      o_free         = !rsp_valid_ff || rsp_ready;
      mv[NUM_STAGES] = !valid_ff[NUM_STAGES] || o_free;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         mv[k] = !valid_ff[k] || mv[k+1];
      end
   end

   // Decode the incoming beat
   always_comb begin
      req_ok = (32'(req_beat.layer) < LAYERS) &&
               (32'(req_beat.position) < PARAMS_PER_LAYER);
      ctl_in.upd         = (req_beat.cmd == CMD_UPDATE);
      ctl_in.ok          = req_ok;
      ctl_in.explored    = ({1'b0, req_beat.uniform_draw} < explore_prob_ff);
      ctl_in.addr        = ADDR_W'(32'(req_beat.layer) * PARAMS_PER_LAYER +
                                   32'(req_beat.position));
      ctl_in.init_weight = req_beat.init_weight;
   end

   // Hold an update while any earlier beat to the same entry has not yet
   // written back; its memory read would return a stale weight and trace.
   always_comb begin
      hit = 1'b0;
      for (int k = 1; k <= NUM_STAGES; k++) begin
         if (valid_ff[k] && ctl_ff[k].ok && (ctl_ff[k].addr == ctl_in.addr)) begin
            hit = 1'b1;
         end
      end
      block     = ctl_in.upd && req_ok && hit;
      req_ready = mv[1] && !block;
      accept    = req_valid && req_ready;
   end

   always_comb begin
      valid_in[1] = mv[1] ? accept : valid_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = mv[k] ? valid_ff[k-1] : valid_ff[k];
      end
      rsp_valid_in = o_free ? valid_ff[NUM_STAGES] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            valid_ff[k] <= valid_in[k];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv[1]) begin
         ctl_ff[1] <= ctl_in;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (mv[k]) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Weight/trace memory: {weight, trace} per entry, read at accept,
   // written when a beat leaves the last stage
   // ---------------------------------------------------------------------
   logic              mem_re;
   logic              mem_we;
   logic [MEM_W-1:0]  mem_wdata;
   logic [MEM_W-1:0]  mem_rd;
   logic signed [31:0] mem_w;
   logic signed [31:0] mem_t;

   logic signed [31:0] s6_wnew_ff;
   logic signed [31:0] s6_tnew_ff;

   assign mem_re = accept;
   assign mem_we = valid_ff[NUM_STAGES] && o_free && ctl_ff[NUM_STAGES].ok;
   // A load writes the initial weight and clears the trace
   assign mem_wdata = ctl_ff[NUM_STAGES].upd ? {s6_wnew_ff, s6_tnew_ff}
                                             : {ctl_ff[NUM_STAGES].init_weight, 32'b0};
   assign mem_w = $signed(mem_rd[63:32]);
   assign mem_t = $signed(mem_rd[31:0]);

   ptwu_ram #(
      .DATA_W (MEM_W),
      .DEPTH  (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (ctl_ff[NUM_STAGES].addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (ctl_in.addr),
      .rd_data (mem_rd)
   );

   // ---------------------------------------------------------------------
   // Arithmetic stages
   // ---------------------------------------------------------------------
   // Stage 1: operands next to the memory read data
   logic signed [31:0] s1_reward_ff;
   logic signed [15:0] s1_gauss_ff;

   always_ff @(posedge clock) begin
      if (mv[1]) begin
         s1_reward_ff <= req_beat.reward;
         s1_gauss_ff  <= req_beat.gauss_draw;
      end
   end

   // Stage 2: the three products; noise is Q8.8 * Q4.12 scaled up to Q8.24
   logic signed [63:0] s2_prt_ff;
   logic signed [49:0] s2_dt_ff;
   logic signed [36:0] s2_noise_ff;
   logic signed [31:0] s2_w_ff;
   logic signed [32:0] noise_prod;

   assign noise_prod = $signed({1'b0, noise_scale_ff}) * s1_gauss_ff;

   always_ff @(posedge clock) begin
      if (mv[2]) begin
         s2_prt_ff   <= s1_reward_ff * mem_t;
         s2_dt_ff    <= $signed({1'b0, trace_decay_ff}) * mem_t;
         s2_noise_ff <= ctl_ff[1].explored ? $signed({noise_prod, 4'b0000}) : 37'sd0;
         s2_w_ff     <= mem_w;
      end
   end

   // Stage 3: round reward*trace to Q8.24 and decay*trace back to Q8.24
   logic signed [63:0] p_sum;
   logic signed [49:0] dt_sum;
   logic signed [39:0] s3_p_ff;
   logic signed [33:0] s3_tdec_ff;
   logic signed [36:0] s3_noise_ff;
   logic signed [31:0] s3_w_ff;

   assign p_sum  = s2_prt_ff + 64'sd8388608;
   assign dt_sum = s2_dt_ff + 50'sd32768;

   always_ff @(posedge clock) begin
      if (mv[3]) begin
         s3_p_ff     <= $signed(p_sum[63:24]);
         s3_tdec_ff  <= $signed(dt_sum[49:16]);
         s3_noise_ff <= s2_noise_ff;
         s3_w_ff     <= s2_w_ff;
      end
   end

   // Stage 4: scale by learn rate; finish the new trace
   logic signed [37:0] t_sum;
   logic signed [56:0] s4_dfull_ff;
   logic signed [31:0] s4_tnew_ff;
   logic signed [36:0] s4_noise_ff;
   logic signed [31:0] s4_w_ff;

   assign t_sum = 38'(s3_tdec_ff) + 38'(s3_noise_ff);

   always_ff @(posedge clock) begin
      if (mv[4]) begin
         s4_dfull_ff <= s3_p_ff * $signed({1'b0, learn_rate_ff});
         s4_tnew_ff  <= sat32(64'(t_sum));
         s4_noise_ff <= s3_noise_ff;
         s4_w_ff     <= s3_w_ff;
      end
   end

   // Stage 5: round the weight step
   logic signed [56:0] d_sum;
   logic signed [40:0] s5_delta_ff;
   logic signed [31:0] s5_tnew_ff;
   logic signed [36:0] s5_noise_ff;
   logic signed [31:0] s5_w_ff;

   assign d_sum = s4_dfull_ff + 57'sd32768;

   always_ff @(posedge clock) begin
      if (mv[5]) begin
         s5_delta_ff <= $signed(d_sum[56:16]);
         s5_tnew_ff  <= s4_tnew_ff;
         s5_noise_ff <= s4_noise_ff;
         s5_w_ff     <= s4_w_ff;
      end
   end

   // Stage 6: reinforced weight
   logic signed [41:0] w_sum;
   logic signed [36:0] s6_noise_ff;

   assign w_sum = 42'(s5_w_ff) + 42'(s5_delta_ff);

   always_ff @(posedge clock) begin
      if (mv[6]) begin
         s6_wnew_ff  <= sat32(64'(w_sum));
         s6_tnew_ff  <= s5_tnew_ff;
         s6_noise_ff <= s5_noise_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register: perturbed parameter, or the load / out-of-range beat
   // ---------------------------------------------------------------------
   logic signed [37:0] pv_sum;

   assign pv_sum = 38'(s6_wnew_ff) + 38'(s6_noise_ff);

   always_comb begin
      if (!ctl_ff[NUM_STAGES].ok) begin
         // drop: address outside the store, no state change
         rsp_in.param_value = 32'sd0;
         rsp_in.explored    = 1'b0;
      end else if (!ctl_ff[NUM_STAGES].upd) begin
         rsp_in.param_value = ctl_ff[NUM_STAGES].init_weight;
         rsp_in.explored    = 1'b0;
      end else begin
         rsp_in.param_value = sat32(64'(pv_sum));
         rsp_in.explored    = ctl_ff[NUM_STAGES].explored;
      end
   end

   always_ff @(posedge clock) begin
      if (o_free && valid_ff[NUM_STAGES]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic s1_conflict;

   always_comb begin
      s1_conflict = 1'b0;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (valid_ff[k] && ctl_ff[k].ok && (ctl_ff[k].addr == ctl_ff[1].addr)) begin
            s1_conflict = 1'b1;
         end
      end
   end

   // Every write-back is paired with a beat entering the response register
   a_wb_to_rsp: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> rsp_valid_ff)
      else $error("write-back without a response beat");

   // Read data always has a stage-1 beat to consume it
   a_rd_lands: assert property (@(posedge clock) disable iff (reset)
      mem_re |=> valid_ff[1])
      else $error("memory read lost");

   // An update in stage 1 never shares its entry with a beat still in flight
   a_no_raw: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && ctl_ff[1].upd && ctl_ff[1].ok) |-> !s1_conflict)
      else $error("update read an entry with a pending write-back");

endmodule

[rtl/ptwu_ram.sv]
module ptwu_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ptwu_pkg::*;

   // Cycles without any beat on either channel before the run is declared hung.
   // The longest legal quiet stretch is the forced receiver hold-off below.
   localparam int unsigned STALL_LIMIT     = 4000;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned PHASE_BEATS     = 140;
   localparam int unsigned DRAIN_CYCLES    = 20;

   // Mirror of the weight and trace memories plus the register file. Every
   // accepted request beat is stepped through the mirror right away and its
   // predicted response is queued; response beats pop the oldest prediction.
   class weight_trace_mirror;
      logic signed [31:0] weight_mem [STORE_DEPTH];
      logic signed [31:0] trace_mem  [STORE_DEPTH];
      logic        [15:0] learn_rate;
      logic        [16:0] trace_decay;
      logic        [16:0] explore_prob;
      logic        [15:0] noise_scale;
      rsp_type            expected_params [$];
      int unsigned        mismatch_count;

      function new();
         learn_rate     = LEARN_RATE_RST;
         trace_decay    = TRACE_DECAY_RST;
         explore_prob   = EXPLORE_PROB_RST;
         noise_scale    = NOISE_SCALE_RST;
         mismatch_count = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         case (index)
            CSR_LEARN_RATE:   learn_rate   = value[15:0];
            CSR_TRACE_DECAY:  trace_decay  = value;
            CSR_EXPLORE_PROB: explore_prob = value;
            CSR_NOISE_SCALE:  noise_scale  = value[15:0];
            default: ;
         endcase
      endfunction

      // floor((v + 2^(n-1)) / 2^n)
      function longint round_half_up(longint v, int unsigned n);
         return (v + (64'sd1 <<< (n - 1))) >>> n;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
         if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
         return v[31:0];
      endfunction

      function void note_request(req_type r);
         int unsigned idx;
         longint      w;
         longint      t;
         longint      p;
         longint      delta;
         longint      noise;
         logic        explored;
         rsp_type     e;
         idx = {r.layer, r.position};
         e   = '0;
         if (r.cmd == CMD_LOAD) begin
            weight_mem[idx] = r.init_weight;
            trace_mem[idx]  = '0;
            e.param_value   = r.init_weight;
         end else begin
            w        = weight_mem[idx];
            t        = trace_mem[idx];
            p        = round_half_up(longint'($signed(r.reward)) * t, 24);
            delta    = round_half_up(p * longint'(learn_rate), 16);
            w        = clamp32(w + delta);
            weight_mem[idx] = w[31:0];
            explored = (r.uniform_draw < explore_prob);
            noise    = explored ?
                       longint'(noise_scale) * longint'($signed(r.gauss_draw)) * 16 : 0;
            e.param_value = clamp32(w + noise);
            e.explored    = explored;
            trace_mem[idx] = clamp32(round_half_up(longint'(trace_decay) * t, 16) + noise);
         end
         expected_params.push_back(e);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_response(rsp_type r);
         rsp_type e;
         if (expected_params.size() == 0) begin
            report_mismatch($sformatf("response with none pending, param_value %0d",
                                      r.param_value));
            return;
         end
         e = expected_params.pop_front();
         if (r.param_value !== e.param_value)
            report_mismatch($sformatf("param_value got %0d expected %0d",
                                      r.param_value, e.param_value));
         if (r.explored !== e.explored)
            report_mismatch($sformatf("explored got %0b expected %0b",
                                      r.explored, e.explored));
      endtask

      task report_leftovers();
         while (expected_params.size() != 0) begin
            report_mismatch($sformatf("no response for expected param_value %0d",
                                      expected_params[0].param_value));
            void'(expected_params.pop_front());
         end
      endtask

      function int unsigned pending();
         return expected_params.size();
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_beat  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_beat;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   weight_trace_mirror param_mirror = new();

   // Stimulus bookkeeping: which entries hold a defined weight, so updates
   // never touch an entry that was never loaded.
   bit          addr_loaded [STORE_DEPTH];
   logic [12:0] loaded_addrs [$];
   logic [12:0] last_addr        = '0;
   logic [16:0] explore_setting  = EXPLORE_PROB_RST;
   bit          quiet_run        = 1'b0;
   bit          hold_off_request = 1'b0;
   int unsigned stalled_cycles   = 0;

   perturbation_trace_weight_update_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Sample every channel at the rising edge, before any of this edge's
   // nonblocking updates land, and feed the mirror in handshake order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) param_mirror.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) param_mirror.note_request(req_beat);
         if (rsp_valid && rsp_ready) param_mirror.check_response(rsp_beat);
      end
   end

   // Hang detector: count edges with no beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stalled_cycles <= 0;
      else stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Response side: drop ready at random, hold it low for a long stretch on
   // request so the pipeline backs up into the request channel.
   initial begin : response_sink
      int unsigned hold_cycles;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_cycles      = RSP_HOLD_CYCLES;
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_run || ($urandom_range(99) >= 29);
         end
      end
   end

   function automatic req_type make_beat(logic cmd, logic [12:0] addr,
                                         logic signed [31:0] reward,
                                         logic [15:0] uniform_draw,
                                         logic signed [15:0] gauss_draw,
                                         logic signed [31:0] init_weight);
      req_type b;
      b.cmd          = cmd;
      b.layer        = addr[12:10];
      b.position     = addr[9:0];
      b.reward       = reward;
      b.uniform_draw = uniform_draw;
      b.gauss_draw   = gauss_draw;
      b.init_weight  = init_weight;
      return b;
   endfunction

   // Offer one beat and hold it until accepted. Idle gaps go ahead of the
   // beat; valid only drops while idling, so back-to-back beats keep it high.
   task automatic send_beat(input req_type b);
      logic [12:0] addr;
      addr = {b.layer, b.position};
      while (!quiet_run && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= b;
      do @(posedge clock); while (!req_ready);
      if (b.cmd == CMD_LOAD && !addr_loaded[addr]) begin
         addr_loaded[addr] = 1'b1;
         loaded_addrs.push_back(addr);
      end
      last_addr = addr;
   endtask

   // Drop valid and wait until every predicted response has come back. The
   // extra edge first lets the monitor account for the last accepted beat.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (param_mirror.pending() != 0) @(posedge clock);
   endtask

   // Write all four registers back to back; only call with the pipeline empty.
   task automatic program_registers(logic [CSR_W-1:0] lr, logic [CSR_W-1:0] td,
                                    logic [CSR_W-1:0] ep, logic [CSR_W-1:0] ns);
      logic [CSR_IDX_W-1:0] idx  [4];
      logic [CSR_W-1:0]     vals [4];
      idx  = '{CSR_LEARN_RATE, CSR_TRACE_DECAY, CSR_EXPLORE_PROB, CSR_NOISE_SCALE};
      vals = '{lr, td, ep, ns};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      explore_setting = ep;
   endtask

   // Mostly updates on loaded entries so traces build up over many steps;
   // repeat the previous entry often to hit the write-back hazard.
   task automatic send_random_beat();
      int unsigned        pick;
      int                 near;
      logic               cmd;
      logic [12:0]        addr;
      logic signed [31:0] reward;
      logic [15:0]        uniform_draw;
      pick = $urandom_range(99);
      if (loaded_addrs.size() == 0 || pick < 12) begin
         cmd = CMD_LOAD;
         // half anywhere in the store, half onto a few hot positions per layer
         if (pick < 6) addr = 13'($urandom);
         else addr = {3'($urandom_range(7)),
                      ($urandom_range(4) == 4) ? 10'd1023 : 10'($urandom_range(3))};
      end else begin
         cmd = CMD_UPDATE;
         if (pick < 40 && addr_loaded[last_addr]) addr = last_addr;
         else addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
      end
      // small rewards keep weights in range; full-scale ones drive saturation
      if ($urandom_range(1)) reward = $urandom;
      else reward = 32'($urandom_range(33554432)) - 32'd16777216;
      // cluster half of the draws around the explore threshold
      if ($urandom_range(1)) begin
         uniform_draw = 16'($urandom);
      end else begin
         near = int'(explore_setting) + int'($urandom_range(8)) - 4;
         if (near < 0) near = 0;
         if (near > 65535) near = 65535;
         uniform_draw = 16'(near);
      end
      send_beat(make_beat(cmd, addr, reward, uniform_draw, 16'($urandom), 32'($urandom)));
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at reset register values.
      // Load both corners of the store and one entry in the middle.
      send_beat(make_beat(CMD_LOAD, {3'd0, 10'd0}, 32'sh0, 16'h0, 16'sh0, 32'sh7FFF_FFFF));
      send_beat(make_beat(CMD_LOAD, {3'd7, 10'd1023}, 32'sh0, 16'h0, 16'sh0,
                          32'sh8000_0000));
      send_beat(make_beat(CMD_LOAD, {3'd3, 10'd512}, 32'sh0, 16'hFFFF, 16'sh0, 32'sh0));
      // Full-scale positive noise on top of the largest weight saturates high.
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh7FFF_FFFF, 16'h0, 16'sh7FFF,
                          32'sh0));
      // No exploring; the largest reward times the fresh trace pushes the weight.
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh7FFF_FFFF, 16'hFFFF, 16'sh7FFF,
                          32'sh0));
      // Just below the threshold explores, exactly at it does not.
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh8000_0000,
                          16'(EXPLORE_PROB_RST - 1), 16'sh8000, 32'sh0));
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh8000_0000,
                          16'(EXPLORE_PROB_RST), 16'sh8000, 32'sh0));
      // Most negative weight plus most negative noise saturates low.
      send_beat(make_beat(CMD_UPDATE, {3'd7, 10'd1023}, 32'sh8000_0000, 16'h0, 16'sh8000,
                          32'sh0));
      send_beat(make_beat(CMD_UPDATE, {3'd7, 10'd1023}, 32'sh7FFF_FFFF, 16'h0, 16'sh8000,
                          32'sh0));
      send_beat(make_beat(CMD_UPDATE, {3'd3, 10'd512}, 32'sh0, 16'h0, 16'sh0, 32'sh0));
      // Reload right behind updates of the same entry clears its trace.
      send_beat(make_beat(CMD_LOAD, {3'd0, 10'd0}, 32'sh7FFF_FFFF, 16'hFFFF, 16'sh7FFF,
                          32'sh0100_0000));
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh7FFF_FFFF, 16'hFFFF, 16'sh7FFF,
                          32'sh0));

      // Top of every range; the value bit above the 16-bit registers is dropped,
      // and a threshold of one explores on every draw.
      wait_for_results();
      program_registers(17'h1FFFF, 17'd65536, 17'd65536, 17'h1FFFF);
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh7FFF_FFFF, 16'hFFFF, 16'sh7FFF,
                          32'sh0));
      send_beat(make_beat(CMD_UPDATE, {3'd7, 10'd1023}, 32'sh7FFF_FFFF, 16'hFFFF,
                          16'sh7FFF, 32'sh0));
      send_beat(make_beat(CMD_UPDATE, {3'd3, 10'd512}, 32'sh8000_0000, 16'hFFFF, 16'sh8000,
                          32'sh0));

      // Everything zero: nothing explores, the trace collapses.
      wait_for_results();
      program_registers('0, '0, '0, '0);
      send_beat(make_beat(CMD_UPDATE, {3'd0, 10'd0}, 32'sh7FFF_FFFF, 16'h0, 16'sh7FFF,
                          32'sh0));
      send_beat(make_beat(CMD_UPDATE, {3'd7, 10'd1023}, 32'sh7FFF_FFFF, 16'h0, 16'sh8000,
                          32'sh0));

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         case (phase)
            0: program_registers(LEARN_RATE_RST, TRACE_DECAY_RST, EXPLORE_PROB_RST,
                                 NOISE_SCALE_RST);
            2: program_registers(17'h1FFFF, 17'd65536, 17'd65536, 17'h1FFFF);
            4: program_registers(17'd65535, 17'd0, 17'd32768, 17'd1);
            default: program_registers(17'($urandom_range(131071)),
                                       17'($urandom_range(65536)),
                                       17'($urandom_range(65536)),
                                       17'($urandom_range(131071)));
         endcase
         // one phase runs flat out on both sides, with a forced response stall
         quiet_run = (phase == 1);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 1 && n == 40) hold_off_request = 1'b1;
            // pause the sender mid-phase until the pipeline is empty
            if (phase == 3 && n == 70) wait_for_results();
            send_random_beat();
         end
      end
      quiet_run = 1'b0;

      // Drain, then give stray responses time to show up.
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      param_mirror.report_leftovers();
      if (param_mirror.mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/ptwu_pkg.sv
rtl/ptwu_ram.sv
rtl/perturbation_trace_weight_update_core.sv
tb/testbench.sv
